@@ hdl/tvf_pkg.sv @@
// ----------------------------------------------------------------------------
// tvf_pkg - shared types and constants of the visible text filter
// Option bit positions, character codes and the command that the front end
// hands to the expansion engine.
// ----------------------------------------------------------------------------
package tvf_pkg;

   // option_set bit positions
   localparam int OPT_NUMBER   = 0;
   localparam int OPT_NONBLANK = 1;
   localparam int OPT_ENDS     = 2;
   localparam int OPT_TABS     = 3;
   localparam int OPT_VISIBLE  = 4;
   localparam int OPT_SQUEEZE  = 5;
   localparam int OPT_WIDTH    = 6;

   // character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] HIGH_BIT  = 8'h80;
   localparam logic [7:0] LOW_MASK  = 8'h7F;
   localparam logic [7:0] CTRL_TOP  = 8'h20;
   localparam logic [7:0] CARET_OR  = 8'h40;

   // queue between front end and expansion engine
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   // tail of one item: up to four bytes after the optional line number
   typedef struct packed {
      logic            has_num;
      logic [1:0]      tail_last;
      logic [3:0][7:0] tail;
   } cmd_type;

   localparam int CMD_WIDTH = $bits(cmd_type);

endpackage

@@ hdl/tvf_front.sv @@
// ----------------------------------------------------------------------------
// tvf_front - byte classifier and line state
// Keeps the mid-line flag, the blank-line flag and the BCD line counter,
// drops squeezed newlines and turns each other byte into an expansion command.
// ----------------------------------------------------------------------------
module tvf_front #(
   parameter int COUNT_DIGITS = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tvf_pkg::OPT_WIDTH-1:0]   csr_wr_data,
   input  logic                            in_take,
   input  logic [7:0]                      in_byte,
   output logic                            push,
   output tvf_pkg::cmd_type                push_cmd,
   output logic [4*COUNT_DIGITS-1:0]       push_digits
);
   import tvf_pkg::*;

   localparam int CW = 4 * COUNT_DIGITS;

   logic [OPT_WIDTH-1:0] option_ff;
   logic                 mid_line_ff, mid_line_in;
   logic                 blank_ff, blank_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        count_inc;
   logic                 want_num;
   logic                 keep;
   logic [7:0]           low7;
   logic [7:0]           b0, b1;
   logic                 two_ch;
   cmd_type              cmd;

   // saturating BCD increment: a digit moves when all lower digits are nine
   always_comb begin
      logic lower_nine;
      logic all_nine;
      lower_nine = 1'b1;
      all_nine   = 1'b1;
      count_inc  = count_ff;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (count_ff[4*i +: 4] != 4'd9) all_nine = 1'b0;
      end
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (lower_nine) begin
            if (count_ff[4*i +: 4] >= 4'd9) count_inc[4*i +: 4] = 4'd0;
            else count_inc[4*i +: 4] = count_ff[4*i +: 4] + 4'd1;
         end
         lower_nine = lower_nine && (count_ff[4*i +: 4] == 4'd9);
      end
      if (all_nine) count_inc = count_ff;
   end

   // caret notation of the low seven bits
   always_comb begin
      low7   = in_byte & LOW_MASK;
      two_ch = 1'b1;
      b1     = CH_QMARK;
      b0     = CH_CARET;
      if (low7 < CTRL_TOP) begin
         b1 = low7 | CARET_OR;
      end else if (low7 == CH_DEL) begin
         b1 = CH_QMARK;
      end else begin
         b0     = low7;
         b1     = 8'h00;
         two_ch = 1'b0;
      end
   end

   // classify the byte and build its command
   always_comb begin
      mid_line_in   = mid_line_ff;
      blank_in      = blank_ff;
      want_num      = 1'b0;
      keep          = 1'b1;
      cmd.tail      = '0;
      cmd.tail_last = 2'd0;
      if (in_byte != CH_LF) begin
         want_num    = option_ff[OPT_NUMBER] && !mid_line_ff;
         mid_line_in = 1'b1;
         blank_in    = 1'b0;
         if (in_byte == CH_TAB) begin
            if (option_ff[OPT_TABS]) begin
               cmd.tail[0]   = CH_CARET;
               cmd.tail[1]   = CH_I;
               cmd.tail_last = 2'd1;
            end else begin
               cmd.tail[0] = CH_TAB;
            end
         end else if (option_ff[OPT_VISIBLE]) begin
            if ((in_byte & HIGH_BIT) != 8'h00) begin
               cmd.tail[0]   = CH_M;
               cmd.tail[1]   = CH_DASH;
               cmd.tail[2]   = b0;
               cmd.tail[3]   = b1;
               cmd.tail_last = two_ch ? 2'd3 : 2'd2;
            end else begin
               cmd.tail[0]   = b0;
               cmd.tail[1]   = b1;
               cmd.tail_last = two_ch ? 2'd1 : 2'd0;
            end
         end else begin
            cmd.tail[0] = in_byte;
         end
      end else if (blank_ff && option_ff[OPT_SQUEEZE]) begin
         keep = 1'b0;
      end else begin
         if (!mid_line_ff) begin
            blank_in = 1'b1;
            want_num = option_ff[OPT_NUMBER] && !option_ff[OPT_NONBLANK];
         end
         mid_line_in = 1'b0;
         if (option_ff[OPT_ENDS]) begin
            cmd.tail[0]   = CH_DOLLAR;
            cmd.tail[1]   = CH_LF;
            cmd.tail_last = 2'd1;
         end else begin
            cmd.tail[0] = CH_LF;
         end
      end
      cmd.has_num = want_num;
      count_in    = want_num ? count_inc : count_ff;
   end

   assign push        = in_take && keep;
   assign push_cmd    = cmd;
   assign push_digits = count_in;

   // hold options and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         option_ff   <= '0;
         mid_line_ff <= 1'b0;
         blank_ff    <= 1'b0;
         count_ff    <= '0;
      end else begin
         if (csr_wr_en) option_ff <= csr_wr_data;
         if (in_take) begin
            mid_line_ff <= mid_line_in;
            blank_ff    <= blank_in;
            count_ff    <= count_in;
         end
      end
   end

endmodule

@@ hdl/tvf_queue.sv @@
// ----------------------------------------------------------------------------
// tvf_queue - short command queue
// Decouples the front end from the expansion engine so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module tvf_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  not_full,
   input  logic                  pop,
   output logic                  pop_valid,
   output logic [DATA_WIDTH-1:0] pop_data
);
   import tvf_pkg::*;

   logic [DATA_WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign not_full  = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // track fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QUEUE_CW'(1);
      else if (pop && !push) count_in = count_ff - QUEUE_CW'(1);
   end

   // store entries
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         count_ff <= count_in;
      end
   end

endmodule

@@ hdl/tvf_back.sv @@
// ----------------------------------------------------------------------------
// tvf_back - expansion engine
// Plays out one command a byte per unstalled cycle: the line number digits
// with leading blanks and a tab, then the tail bytes, into an output register.
// ----------------------------------------------------------------------------
module tvf_back #(
   parameter int COUNT_DIGITS = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  tvf_pkg::cmd_type            q_cmd,
   input  logic [4*COUNT_DIGITS-1:0]   q_digits,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast
);
   import tvf_pkg::*;

   localparam int CW = 4 * COUNT_DIGITS;
   localparam int IW = $clog2(COUNT_DIGITS + 1);

   cmd_type       cur_ff;
   logic [CW-1:0] digits_ff;
   logic          cur_valid_ff;
   logic          in_num_ff;
   logic          leading_ff;
   logic [IW-1:0] idx_ff;
   logic [1:0]    tail_idx_ff;
   logic          out_valid_ff;
   logic [7:0]    out_data_ff;
   logic          out_last_ff;

   logic          out_free;
   logic          step;
   logic          last;
   logic          load;
   logic          at_tab;
   logic [3:0]    sel_digit;
   logic          sel_units;
   logic          is_space;
   logic [7:0]    cur_byte;

   assign out_free = !out_valid_ff || rsp_tready;
   assign step     = cur_valid_ff && out_free;
   assign at_tab   = (idx_ff == IW'(COUNT_DIGITS));
   assign last     = !in_num_ff && (tail_idx_ff == cur_ff.tail_last);
   assign load     = q_valid && (!cur_valid_ff || (step && last));
   assign q_pop    = load;

   // pick the digit for the current column, most significant first
   always_comb begin
      sel_digit = 4'd0;
      sel_units = 1'b0;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (idx_ff == IW'(COUNT_DIGITS - 1 - i)) begin
            sel_digit = digits_ff[4*i +: 4];
            sel_units = (i == 0);
         end
      end
   end

   // select the byte to send
   always_comb begin
      is_space = leading_ff && (sel_digit == 4'd0) && !sel_units;
      if (in_num_ff) begin
         if (at_tab) cur_byte = CH_TAB;
         else if (is_space) cur_byte = CH_SPACE;
         else cur_byte = CH_ZERO | {4'd0, sel_digit};
      end else begin
         cur_byte = cur_ff.tail[tail_idx_ff];
      end
   end

   // sequence through the current command
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         in_num_ff    <= 1'b0;
         leading_ff   <= 1'b1;
         idx_ff       <= '0;
         tail_idx_ff  <= '0;
      end else if (load) begin
         cur_valid_ff <= 1'b1;
         in_num_ff    <= q_cmd.has_num;
         leading_ff   <= 1'b1;
         idx_ff       <= '0;
         tail_idx_ff  <= '0;
      end else if (step) begin
         if (in_num_ff) begin
            if (at_tab) begin
               in_num_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + IW'(1);
               if (!is_space) leading_ff <= 1'b0;
            end
         end else if (last) begin
            cur_valid_ff <= 1'b0;
         end else begin
            tail_idx_ff <= tail_idx_ff + 2'd1;
         end
      end
   end

   // hold command payload
   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff    <= q_cmd;
         digits_ff <= q_digits;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= cur_byte;
         out_last_ff <= last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ hdl/text_stream_visible_filter.sv @@
// ----------------------------------------------------------------------------
// text_stream_visible_filter - text filter in the manner of cat -nbETvs
// Numbers lines, marks line ends, shows tabs and nonprinting bytes and
// squeezes runs of blank lines, one input byte per transfer.
//
//   channel | direction | tdata                   | tlast
//   req     | in        | [7:0] in_byte           | -
//   rsp     | out       | [7:0] out_byte          | last_of_run
//   csr     | in        | [5:0] option_set        | -
//
// An input byte is taken every cycle while the four-entry command queue has
// room; its output bytes (1 to COUNT_DIGITS+5) leave the expansion engine
// one per cycle while rsp_tready is high, the sustained output rate.
// The first output passes the queue slot, the command and output registers.
// A squeezed newline produces no output transfer.
// Synchronous reset clears the line state, the counter and the options.
// rsp_tready low stalls only the engine; the queue takes input while not full.
// ----------------------------------------------------------------------------
module text_stream_visible_filter #(
   parameter int COUNT_DIGITS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [tvf_pkg::OPT_WIDTH-1:0] csr_wr_data,   // [5:0] option_set
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,     // [7:0] in_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,     // [7:0] out_byte
   output logic                          rsp_tlast
);
   import tvf_pkg::*;

   localparam int CW = 4 * COUNT_DIGITS;
   localparam int QW = CMD_WIDTH + CW;

   logic          in_take;
   logic          push;
   cmd_type       push_cmd;
   logic [CW-1:0] push_digits;
   logic          q_ready;
   logic          q_valid;
   logic          q_pop;
   logic [QW-1:0] q_data;
   cmd_type       q_cmd;
   logic [CW-1:0] q_digits;

   assign req_tready = q_ready;
   assign in_take    = req_tvalid && q_ready;
   assign q_cmd      = cmd_type'(q_data[QW-1:CW]);
   assign q_digits   = q_data[CW-1:0];

   tvf_front #(.COUNT_DIGITS(COUNT_DIGITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_take     (in_take),
      .in_byte     (req_tdata),
      .push        (push),
      .push_cmd    (push_cmd),
      .push_digits (push_digits)
   );

   tvf_queue #(.DATA_WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_digits}),
      .not_full  (q_ready),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   tvf_back #(.COUNT_DIGITS(COUNT_DIGITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_digits   (q_digits),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ hdl/tvf_checker.sv @@
// ----------------------------------------------------------------------------
// tvf_checker - port-level checks of the visible text filter
// Watches reset behavior and output stalls on the top level's ports.
// ----------------------------------------------------------------------------
module tvf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // drop any pending output on reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // queue is empty after reset, so input is taken
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req_tready low right after reset");

   // with nothing queued and no input, no output can start
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_tvalid |=> !rsp_tvalid)
      else $error("output transfer without input");

   // hold a stalled output
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output changed");

endmodule

bind text_stream_visible_filter tvf_checker u_tvf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/tb_text_stream_visible_filter.sv @@
// ----------------------------------------------------------------------------
// tb_text_stream_visible_filter - self-checking bench for the text filter
// Feeds raw text bytes under a series of option settings, predicts every
// output byte and its end-of-run flag in a local model of the line state and
// counter, and compares each output transfer against the oldest prediction.
// Random stalls on both channels, a long output hold and a quiet tail.
// ----------------------------------------------------------------------------
module tb_text_stream_visible_filter;
   import tvf_pkg::*;

   localparam int COUNT_DIGITS   = 6;
   localparam int DRAIN_CYCLES   = 12;
   localparam int LONG_HOLD      = 120;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 10;

   // option masks built from the package bit positions
   localparam logic [OPT_WIDTH-1:0] OPTS_NONE  = '0;
   localparam logic [OPT_WIDTH-1:0] OPTS_ALL   = '1;
   localparam logic [OPT_WIDTH-1:0] M_NUMBER   = OPT_WIDTH'(1 << OPT_NUMBER);
   localparam logic [OPT_WIDTH-1:0] M_NONBLANK = OPT_WIDTH'(1 << OPT_NONBLANK);
   localparam logic [OPT_WIDTH-1:0] M_ENDS     = OPT_WIDTH'(1 << OPT_ENDS);
   localparam logic [OPT_WIDTH-1:0] M_TABS     = OPT_WIDTH'(1 << OPT_TABS);
   localparam logic [OPT_WIDTH-1:0] M_VISIBLE  = OPT_WIDTH'(1 << OPT_VISIBLE);
   localparam logic [OPT_WIDTH-1:0] M_SQUEEZE  = OPT_WIDTH'(1 << OPT_SQUEEZE);

   typedef struct packed {
      logic [7:0] glyph;
      logic       run_end;
   } out_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [OPT_WIDTH-1:0] csr_wr_data = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 rsp_tlast;

   // local copy of the filter state
   logic [OPT_WIDTH-1:0] option_bits = '0;
   logic                 in_line = 1'b0;
   logic                 last_line_blank = 1'b0;
   logic [3:0]           line_digits [COUNT_DIGITS] = '{default: 4'd0};
   logic [7:0]           run_glyphs [$];
   out_beat_type         filtered_expect [$];
   out_beat_type         oldest_beat;

   bit tx_gaps = 1'b0;
   bit rx_gaps = 1'b0;
   bit rx_hold_req = 1'b0;
   int rx_gap_left = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   text_stream_visible_filter #(
      .COUNT_DIGITS(COUNT_DIGITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // advance the line counter (saturating at all nines) and append its text
   function automatic void append_line_number();
      bit all_nine;
      bit carry;
      bit leading;
      all_nine = 1'b1;
      carry    = 1'b1;
      leading  = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++)
         if (line_digits[i] != 4'd9) all_nine = 1'b0;
      if (!all_nine) begin
         for (int i = 0; i < COUNT_DIGITS; i++) begin
            if (carry) begin
               if (line_digits[i] == 4'd9) begin
                  line_digits[i] = 4'd0;
               end else begin
                  line_digits[i] = line_digits[i] + 4'd1;
                  carry = 1'b0;
               end
            end
         end
      end
      for (int i = COUNT_DIGITS - 1; i >= 0; i--) begin
         if (leading && line_digits[i] == 4'd0 && i > 0) begin
            run_glyphs.push_back(CH_SPACE);
         end else begin
            leading = 1'b0;
            run_glyphs.push_back(CH_ZERO + 8'(line_digits[i]));
         end
      end
      run_glyphs.push_back(CH_TAB);
   endfunction

   // work out the output bytes one accepted input byte causes
   function automatic void predict_filter(input logic [7:0] raw);
      logic [7:0]   ch;
      out_beat_type beat;
      run_glyphs.delete();
      ch = raw;
      if (raw != CH_LF) begin
         if (option_bits[OPT_NUMBER] && !in_line) append_line_number();
         in_line = 1'b1;
         if (raw == CH_TAB) begin
            if (option_bits[OPT_TABS]) begin
               run_glyphs.push_back(CH_CARET);
               run_glyphs.push_back(CH_I);
            end else begin
               run_glyphs.push_back(CH_TAB);
            end
         end else if (option_bits[OPT_VISIBLE]) begin
            if ((ch & HIGH_BIT) != 8'h00) begin
               run_glyphs.push_back(CH_M);
               run_glyphs.push_back(CH_DASH);
               ch = ch & LOW_MASK;
            end
            if (ch < CTRL_TOP) begin
               run_glyphs.push_back(CH_CARET);
               run_glyphs.push_back(ch | CARET_OR);
            end else if (ch == CH_DEL) begin
               run_glyphs.push_back(CH_CARET);
               run_glyphs.push_back(CH_QMARK);
            end else begin
               run_glyphs.push_back(ch);
            end
         end else begin
            run_glyphs.push_back(ch);
         end
         last_line_blank = 1'b0;
      end else if (!(last_line_blank && option_bits[OPT_SQUEEZE])) begin
         if (!in_line) begin
            last_line_blank = 1'b1;
            if (option_bits[OPT_NUMBER] && !option_bits[OPT_NONBLANK])
               append_line_number();
         end
         if (option_bits[OPT_ENDS]) run_glyphs.push_back(CH_DOLLAR);
         run_glyphs.push_back(CH_LF);
         in_line = 1'b0;
      end
      foreach (run_glyphs[i]) begin
         beat.glyph   = run_glyphs[i];
         beat.run_end = (i == run_glyphs.size() - 1);
         filtered_expect.push_back(beat);
      end
   endfunction

   // text-like byte mix: newlines at the given percentage, tabs, controls,
   // high bytes, delete and printable characters
   function automatic logic [7:0] random_text_byte(input int lf_pct);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < lf_pct) return CH_LF;
      pick = $urandom_range(0, 99);
      if (pick < 10) return CH_TAB;
      if (pick < 25) return 8'($urandom_range(0, 31));
      if (pick < 45) return 8'($urandom_range(128, 255));
      if (pick < 50) return CH_DEL;
      return 8'($urandom_range(32, 126));
   endfunction

   // offer one byte, optionally after an idle burst, and hold until transfer
   task automatic send_text_byte(input logic [7:0] raw);
      int gap;
      if (tx_gaps && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      do @(posedge clock); while (!req_tready);
      predict_filter(raw);
   endtask

   // stop offering and wait until every predicted byte has left the block
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      while (filtered_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_options(input logic [OPT_WIDTH-1:0] value);
      drain_outputs();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      option_bits = value;
   endtask

   task automatic send_random_text(input int count, input int lf_pct);
      for (int i = 0; i < count; i++) send_text_byte(random_text_byte(lf_pct));
   endtask

   // byte extremes, every option and the corner cases of each option
   task automatic test_directed_cases();
      // options still at reset: raw pass-through of the extreme bytes
      send_text_byte(8'h00);
      send_text_byte(8'hFF);
      send_text_byte(CH_LF);
      // nonblank-only without numbering does nothing
      write_options(M_NONBLANK);
      send_text_byte(CH_LF);
      send_text_byte(8'h41);
      send_text_byte(CH_LF);
      // everything on: squeezed blank lines, the widest expansion, tab, delete
      write_options(OPTS_ALL);
      send_text_byte(CH_LF);
      send_text_byte(CH_LF);
      send_text_byte(CH_LF);
      send_text_byte(8'h81);
      send_text_byte(CH_TAB);
      send_text_byte(CH_DEL);
      send_text_byte(8'hFF);
      send_text_byte(8'hA0);
      send_text_byte(CH_LF);
      // nonprinting alone: tab and newline pass unchanged
      write_options(M_VISIBLE);
      send_text_byte(CH_TAB);
      send_text_byte(8'h1F);
      send_text_byte(CH_LF);
      send_text_byte(8'h80);
      // number every line, blank ones included
      write_options(M_NUMBER);
      send_text_byte(CH_LF);
      send_text_byte(CH_LF);
   endtask

   // many short lines so the decimal counter carries across digits
   task automatic test_line_count_carry();
      write_options(M_NUMBER | M_ENDS);
      send_random_text(70, 80);
      drain_outputs();
   endtask

   // hold the output while input keeps coming, then pause the input to empty
   task automatic test_output_backpressure();
      bit saved_tx_gaps;
      write_options(M_NUMBER | M_VISIBLE);
      saved_tx_gaps = tx_gaps;
      tx_gaps = 1'b0;
      rx_hold_req = 1'b1;
      send_random_text(24, 15);
      tx_gaps = saved_tx_gaps;
      drain_outputs();
      send_random_text(12, 25);
      drain_outputs();
   endtask

   task automatic test_random_options();
      logic [OPT_WIDTH-1:0] option_plan [8];
      option_plan = '{OPTS_ALL, OPTS_NONE, M_NUMBER | M_NONBLANK | M_SQUEEZE,
                      M_NONBLANK | M_TABS, M_NUMBER | M_ENDS | M_VISIBLE,
                      M_SQUEEZE | M_TABS | M_NUMBER,
                      OPT_WIDTH'($urandom_range(0, 63)),
                      OPT_WIDTH'($urandom_range(0, 63))};
      foreach (option_plan[p]) begin
         write_options(option_plan[p]);
         send_random_text(11, 30);
      end
      drain_outputs();
   endtask

   // back-to-back traffic on both sides
   task automatic test_steady_stream();
      write_options(M_NUMBER | M_ENDS | M_TABS | M_VISIBLE);
      send_random_text(20, 25);
      drain_outputs();
   endtask

   // receiver: random stall bursts, or one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_gap_left = 0;
      end else begin
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_gap_left = LONG_HOLD;
         end else if (rx_gap_left == 0 && rx_gaps && $urandom_range(0, 5) == 0) begin
            rx_gap_left = $urandom_range(1, 12);
         end
         if (rx_gap_left > 0) begin
            rx_gap_left = rx_gap_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each output transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filtered_expect.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected output transfer: byte %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            oldest_beat = filtered_expect.pop_front();
            if (rsp_tdata !== oldest_beat.glyph || rsp_tlast !== oldest_beat.run_end) begin
               mismatches = mismatches + 1;
               if (mismatches <= REPORT_LIMIT)
                  $display("output mismatch: expected byte %h last %b, got byte %h last %b",
                           oldest_beat.glyph, oldest_beat.run_end, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      test_directed_cases();
      test_line_count_carry();
      test_output_backpressure();
      test_random_options();
      // quiet tail: no idling on either side
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      test_steady_stream();
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
